### src/rfps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotating fanout peer select - shared types and constants
// Request, response and classified-request structs used across the block.
// ----------------------------------------------------------------------------
package rfps_pkg;

    localparam int MASK_W  = 32;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 5;
    localparam int SEQ_W   = 64;
    localparam int FANO_W  = 8;
    localparam int DIGIT_W = 8;
    localparam int STAGES  = SEQ_W / DIGIT_W;

    // Configuration register indexes.
    localparam logic REG_FANOUT = 1'b0;

    typedef struct packed {
        logic [MASK_W-1:0] peer_ready_mask;
        logic              exclude_valid;
        logic [IDX_W-1:0]  exclude_index;
        logic [SEQ_W-1:0]  event_seq;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0] send_mask;
        logic [CNT_W-1:0]  sent_count;
        logic [CNT_W-1:0]  eligible_count;
    } t_rsp;

    // A request after classification: who is eligible, how many, and the
    // fanout already limited to the eligible count (zero when nothing goes out).
    typedef struct packed {
        logic [MASK_W-1:0] elig_mask;
        logic [CNT_W-1:0]  elig_count;
        logic [CNT_W-1:0]  fanout_eff;
        logic [SEQ_W-1:0]  event_seq;
    } t_cls;

endpackage
`default_nettype wire

### src/rotating_fanout_peer_select_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotating fanout peer select core
// Picks a rotating run of eligible peer links for each event to be sent to.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake                         | Payload
//  ----------+-----------+-----------------------------------+----------------
//  request   | in        | start, taken when busy is low     | i_req (t_req)
//  response  | out       | o_done strobe, one cycle, no hold | o_rsp (t_rsp)
//  config    | in/out    | APB write/read, pready tied high  | fanout @ 0x0
//
// One request can be accepted every clock cycle. Its response appears on
// o_rsp with o_done high once the request has passed, in order, the
// decoupling queue, the modulo pipeline (eight sequence bits per stage)
// and the output register. busy rises only if the two-entry queue fills,
// which the back end never allows since it drains every cycle.
// Synchronous active-low reset clears all valid flags and sets fanout to 2.
// The receiver cannot stall, so responses are never held back.
//
// The front part masks the ready links with the excluded link and the peer
// limit, counts them and limits the fanout. The back part computes the
// sequence number modulo the eligible count one digit per stage and finally
// ranks each eligible peer by the number of eligible peers below it,
// selecting the run that starts at the rotation and wraps.
// ----------------------------------------------------------------------------
module rotating_fanout_peer_select_core #(
    parameter int MAX_PEERS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // Request channel.
    input  wire logic           start,
    output logic                busy,
    input  wire rfps_pkg::t_req i_req,
    // Response channel.
    output logic                o_done,
    output rfps_pkg::t_rsp      o_rsp,
    // Configuration port.
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rfps_pkg::*;

    // Configuration register. The register index is the word address.
    logic [FANO_W-1:0] r_fanout;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fanout <= FANO_W'(2);
        end else if (cfg_wr && paddr[2] == REG_FANOUT) begin
            r_fanout <= pwdata[FANO_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_FANOUT) begin
            prdata = {{(32-FANO_W){1'b0}}, r_fanout};
        end else begin
            prdata = '0;
        end
    end

    // Front: classify the request as it is accepted.
    t_cls front_cls;
    logic accept;

    assign accept = start && !busy;

    rfps_front #(
        .MAX_PEERS (MAX_PEERS)
    ) u_front (
        .i_req    (i_req),
        .i_fanout (r_fanout),
        .o_cls    (front_cls)
    );

    // Queue between the front and back parts.
    logic q_empty;
    t_cls q_data;

    rfps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cls),
        .i_pop   (!q_empty),
        .o_full  (busy),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // Back: the back end takes a queued request every cycle one is present.
    rfps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_cls   (q_data),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

### src/rfps_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotating fanout peer select - front classifier
// Builds the eligible peer mask, counts it and limits the fanout.
// ----------------------------------------------------------------------------
module rfps_front #(
    parameter int MAX_PEERS = 32
) (
    input  wire rfps_pkg::t_req              i_req,
    input  wire logic [rfps_pkg::FANO_W-1:0] i_fanout,
    output rfps_pkg::t_cls                   o_cls
);
    import rfps_pkg::*;

    localparam int Lim = (MAX_PEERS > MASK_W) ? MASK_W : MAX_PEERS;

    logic [MASK_W-1:0] elig;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  fo;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            elig[i] = (i < Lim) && i_req.peer_ready_mask[i]
                      && !(i_req.exclude_valid && (i_req.exclude_index == IDX_W'(i)));
        end
        cnt = CNT_W'($countones(elig));
    end

    always_comb begin
        if (cnt == '0 || i_fanout == '0) begin
            fo = '0;
        end else if (i_fanout > {{(FANO_W-CNT_W){1'b0}}, cnt}) begin
            fo = cnt;
        end else begin
            fo = i_fanout[CNT_W-1:0];
        end
    end

    assign o_cls.elig_mask  = elig;
    assign o_cls.elig_count = cnt;
    assign o_cls.fanout_eff = fo;
    assign o_cls.event_seq  = i_req.event_seq;

endmodule
`default_nettype wire

### src/rfps_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotating fanout peer select - decoupling queue
// Two-entry queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module rfps_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rfps_pkg::t_cls i_data,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output rfps_pkg::t_cls      o_data
);
    import rfps_pkg::*;

    t_cls       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       n_wptr, n_rptr;
    logic [1:0] n_count;
    logic       push_ok, pop_ok;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = push_ok ? ~r_wptr : r_wptr;
        n_rptr  = pop_ok ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### src/rfps_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotating fanout peer select - back end
// Pipelined sequence-modulo-count and ranked peer selection.
// ----------------------------------------------------------------------------
module rfps_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire rfps_pkg::t_cls i_cls,
    output logic                o_done,
    output rfps_pkg::t_rsp      o_rsp
);
    import rfps_pkg::*;

    // One radix-2 remainder step per sequence bit, a digit per stage.
    function automatic logic [CNT_W-1:0] f_mod_digit(input logic [CNT_W-1:0] rem,
                                                     input logic [DIGIT_W-1:0] dig,
                                                     input logic [CNT_W-1:0] n);
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        r = rem;
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            t = {r, dig[j]};
            if (t >= {1'b0, n}) begin
                t = t - {1'b0, n};
            end
            r = t[CNT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] f_count_below(input logic [MASK_W-1:0] m,
                                                       input int unsigned pos);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int unsigned j = 0; j < MASK_W; j++) begin
            if (j < pos && m[j]) begin
                c = c + CNT_W'(1);
            end
        end
        return c;
    endfunction

    logic             r_vld [STAGES];
    t_cls             r_cls [STAGES];
    logic [CNT_W-1:0] r_rem [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic             vld_in;
            t_cls             cls_in;
            logic [CNT_W-1:0] rem_in;

            if (s == 0) begin : g_first
                assign vld_in = i_valid;
                assign cls_in = i_cls;
                assign rem_in = '0;
            end else begin : g_next
                assign vld_in = r_vld[s-1];
                assign cls_in = r_cls[s-1];
                assign rem_in = r_rem[s-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_cls[s] <= cls_in;
                r_rem[s] <= f_mod_digit(rem_in,
                                        cls_in.event_seq[SEQ_W-1-s*DIGIT_W -: DIGIT_W],
                                        cls_in.elig_count);
            end
        end
    endgenerate

    // Selection: the run of eligible peers from number rot, fanout long, wrapping.
    t_cls             last;
    logic [CNT_W-1:0] rot;
    logic [CNT_W:0]   run_end;
    logic             wrap;
    logic [CNT_W-1:0] wrap_end;
    logic [MASK_W-1:0] sel;
    logic [CNT_W-1:0] k;

    assign last     = r_cls[STAGES-1];
    assign rot      = r_rem[STAGES-1];
    assign run_end  = {1'b0, rot} + {1'b0, last.fanout_eff};
    assign wrap     = run_end > {1'b0, last.elig_count};
    assign wrap_end = CNT_W'(run_end - {1'b0, last.elig_count});

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            k = f_count_below(last.elig_mask, i);
            if (wrap) begin
                sel[i] = last.elig_mask[i] && ((k >= rot) || (k < wrap_end));
            end else begin
                sel[i] = last.elig_mask[i] && (k >= rot) && ({1'b0, k} < run_end);
            end
        end
    end

    logic r_done;
    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp.send_mask      <= sel;
        r_rsp.sent_count     <= last.fanout_eff;
        r_rsp.eligible_count <= last.elig_count;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating fanout peer select core - self-checking testbench
// Drives peer events through the command-style request port, reprograms the
// fanout register over APB between phases, and compares every response with
// an independent prediction of the selected run of eligible peers.
// ----------------------------------------------------------------------------
module tb;
    import rfps_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 16;
    localparam int IDLE_PCT     = 27;
    localparam int RANDOM_ITEMS = 128;    // per phase
    localparam int NUM_PHASES   = 10;
    localparam int CALM_PHASE   = 3;      // request side never idles here
    localparam int MAX_SHOWN    = 10;

    // Register index one has no register behind it; writes there are dropped.
    localparam int         REG_SPARE   = 1;
    localparam logic [2:0] ADDR_FANOUT = 3'(int'(REG_FANOUT) * 4);
    localparam logic [2:0] ADDR_SPARE  = 3'(REG_SPARE * 4);

    // Fanout per phase; a negative entry draws a random value.
    localparam int FANOUT_PLAN [NUM_PHASES] = '{2, 0, 255, 1, 32, 31, 33, -1, 3, -1};

    // Predicts which peers each event is sent to and holds the predictions.
    class peer_pick_checker;
        logic [FANO_W-1:0] fanout;
        t_rsp              pending_picks[$];
        int                mismatches;

        function new();
            fanout     = 8'd2;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%s", msg);
        endfunction

        // Eligible peers are numbered in bit order; the run of fanout peers
        // starts at event_seq mod n and wraps past the highest peer.
        function t_rsp pick_peers(t_req r);
            logic [MASK_W-1:0] elig;
            logic [SEQ_W-1:0]  count64;
            int                n;
            int                fo;
            int                rot;
            int                k;
            t_rsp              p;
            elig = r.peer_ready_mask;
            if (r.exclude_valid)
                elig[r.exclude_index] = 1'b0;
            n = $countones(elig);
            p.send_mask = '0;
            if (n != 0 && fanout != 0) begin
                fo      = (int'(fanout) > n) ? n : int'(fanout);
                count64 = SEQ_W'(n);
                rot     = int'(r.event_seq % count64);
                k       = 0;
                for (int i = 0; i < MASK_W; i++) begin
                    if (elig[i]) begin
                        if ((k + n - rot) % n < fo)
                            p.send_mask[i] = 1'b1;
                        k++;
                    end
                end
            end
            p.sent_count     = CNT_W'($countones(p.send_mask));
            p.eligible_count = CNT_W'(n);
            return p;
        endfunction

        function void note_request(t_req r);
            pending_picks.push_back(pick_peers(r));
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_picks.size() == 0) begin
                report($sformatf("unexpected response: mask %h sent %0d eligible %0d",
                                 got.send_mask, got.sent_count, got.eligible_count));
                return;
            end
            want = pending_picks.pop_front();
            if (got.send_mask !== want.send_mask || got.sent_count !== want.sent_count
                    || got.eligible_count !== want.eligible_count)
                report($sformatf({"response mismatch: mask %h/%h sent %0d/%0d ",
                                  "eligible %0d/%0d (expected/actual)"},
                                 want.send_mask, got.send_mask, want.sent_count,
                                 got.sent_count, want.eligible_count, got.eligible_count));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int               cycles = 0;
    peer_pick_checker board  = new();

    rotating_fanout_peer_select_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Responses cannot be held off, so every strobe is checked at its edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result(o_rsp);
    end

    function automatic t_req make_event(logic [31:0] mask, logic ex_on, logic [4:0] ex_idx,
                                        logic [63:0] seq);
        t_req r;
        r.peer_ready_mask = mask;
        r.exclude_valid   = ex_on;
        r.exclude_index   = ex_idx;
        r.event_seq       = seq;
        return r;
    endfunction

    function automatic t_req draw_event();
        t_req r;
        case ($urandom_range(15))
            0:       r.peer_ready_mask = '0;
            1:       r.peer_ready_mask = '1;
            2:       r.peer_ready_mask = 32'd1 << $urandom_range(31);
            3, 4:    r.peer_ready_mask = $urandom & $urandom & $urandom;
            5:       r.peer_ready_mask = 32'($urandom_range(1, 15));
            default: r.peer_ready_mask = $urandom;
        endcase
        case ($urandom_range(3))
            0:       r.event_seq = 64'($urandom_range(200));
            1:       r.event_seq = '1 - 64'($urandom_range(200));
            default: r.event_seq = {$urandom, $urandom};
        endcase
        r.exclude_valid = 1'($urandom_range(1));
        r.exclude_index = 5'($urandom_range(31));
        // Mostly aim the exclusion at a ready link so that it matters.
        if (r.peer_ready_mask != 0 && $urandom_range(2) != 0)
            while (!r.peer_ready_mask[r.exclude_index])
                r.exclude_index = 5'($urandom_range(31));
        return r;
    endfunction

    task automatic send_event(input t_req r, input bit calm);
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FANOUT)
            board.fanout = data[FANO_W-1:0];
    endtask

    task automatic check_fanout_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_FANOUT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(board.fanout))
            board.report($sformatf("fanout readback: expected %h actual %h",
                                   32'(board.fanout), got));
    endtask

    task automatic drain_responses();
        while (board.pending_picks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Corner events: empty and full masks, exclusion of ready and non-ready
    // links, a fully excluded mask, wrapped runs and extreme sequence values.
    task automatic directed_events(input int phase);
        case (phase)
            0: begin
                send_event(make_event('0, 1'b0, 5'd0, '0), 1'b0);
                send_event(make_event('1, 1'b0, 5'd0, '0), 1'b0);
                send_event(make_event('1, 1'b0, 5'd0, '1), 1'b0);
                send_event(make_event('1, 1'b1, 5'd31, 64'd7), 1'b0);
                send_event(make_event(32'h0000_0020, 1'b1, 5'd5, 64'd3), 1'b0);
                send_event(make_event(32'h0000_0020, 1'b1, 5'd6, 64'd3), 1'b0);
                send_event(make_event(32'h8000_0001, 1'b0, 5'd0, 64'd1), 1'b0);
                send_event(make_event(32'h8000_0000, 1'b0, 5'd0, '1), 1'b0);
                send_event(make_event(32'hAAAA_AAAA, 1'b0, 5'd1, 64'd17), 1'b0);
                send_event(make_event(32'h5555_5555, 1'b0, 5'd0, 64'd15), 1'b0);
                send_event(make_event(32'h0000_0007, 1'b1, 5'd0, '1), 1'b0);
                send_event(make_event('1, 1'b1, 5'd0, 64'h1_0000_0000), 1'b0);
            end
            1: begin
                // A zero fanout still reports the true eligible count.
                send_event(make_event('1, 1'b0, 5'd0, 64'd9), 1'b0);
                send_event(make_event(32'hF0F0_0F0F, 1'b1, 5'd3, '1), 1'b0);
                send_event(make_event('0, 1'b1, 5'd31, '0), 1'b0);
            end
            2: begin
                // Fanout above the eligible count selects every eligible peer.
                send_event(make_event('1, 1'b0, 5'd0, '1), 1'b0);
                send_event(make_event(32'h0000_0003, 1'b0, 5'd0, '1), 1'b0);
                send_event(make_event('1, 1'b1, 5'd16, 64'h8000_0000_0000_0000), 1'b0);
            end
            default: ;
        endcase
    endtask

    initial begin
        int fo;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // The block is idle here: every expected response has arrived.
            if (phase != 0) begin
                fo = (FANOUT_PLAN[phase] < 0) ? $urandom_range(255) : FANOUT_PLAN[phase];
                apb_write(ADDR_SPARE, $urandom);
                apb_write(ADDR_FANOUT, {24'($urandom), 8'(fo)});
            end
            check_fanout_readback();
            directed_events(phase);
            for (int n = 0; n < RANDOM_ITEMS; n++)
                send_event(draw_event(), phase == CALM_PHASE);
            start <= 1'b0;
            drain_responses();
        end

        if (board.pending_picks.size() != 0)
            board.report($sformatf("%0d responses never arrived",
                                   board.pending_picks.size()));
        if (board.mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
